// ----- sv/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// Deadline task scheduler package
// Sizes, function codes, status codes, task kinds and sequencer states.
// ----------------------------------------------------------------------------
package dts_pkg;

	localparam int SLOTS     = 32;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int IDX_W     = $clog2(SLOTS + 1);
	localparam int FRAC_BITS = 24;

	// root of the queue, also the code for "no slot"
	localparam logic [IDX_W-1:0] ROOT = IDX_W'(SLOTS);

	typedef enum logic [2:0] {
		F_ADD_SLEEP = 3'd0,
		F_ADD_PER   = 3'd1,
		F_ADJUST    = 3'd2,
		F_WAKE      = 3'd3,
		F_CANCEL    = 3'd4,
		F_DISPATCH  = 3'd5,
		F_COMPLETE  = 3'd6,
		F_NOP       = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_SLOT = 2'd1,
		ST_NOT_DUE = 2'd2,
		ST_NOT_RUN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_CANCELED = 2'd0,
		K_SLEEP    = 2'd1,
		K_PERIODIC = 2'd2,
		K_UNUSED   = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_APPLY  = 6'b000100,
		S_SEEK   = 6'b001000,
		S_INS    = 6'b010000,
		S_CAN    = 6'b100000
	} state_t;

endpackage

// ----- sv/dts_mul.sv -----
// ----------------------------------------------------------------------------
// Interval multiplier
// Registered 32x32 product of an 8.24 interval and the tick frequency.
// ----------------------------------------------------------------------------
module dts_mul import dts_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] ticks
);

	logic [63:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(a) * 64'(b);
	end

	assign ticks = prod_s1[FRAC_BITS+31:FRAC_BITS];

endmodule

// ----- sv/deadline_task_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// Deadline task scheduler
// Task slot pool with a free stack and a due-time sorted queue.
// ----------------------------------------------------------------------------
// Usage: pulse start with func and its operands while busy is low; the
// transaction is taken at that edge and busy rises. When the operation ends,
// done is high for exactly one cycle with status, task_slot, task_kind,
// out_call_tag and out_ref_tag; busy is low in that same cycle, so the next
// transaction may start there. The receiver cannot stall the result.
// Dispatch, adjust, complete of a canceled task, and errors end without a
// queue walk. Adds walk the sorted queue one linked slot per cycle through
// the wraparound compare; wakes and completes of a live task walk it
// likewise. Cancel walks the whole queue, one slot per cycle. The queue walk
// over the link table sets the rate.
// cfg_we writes clock_frequency at any edge; write it only while idle.
// Reset empties the queue, chains all slots on the free stack and sets
// clock_frequency to 120000000; it takes effect at once.
// ----------------------------------------------------------------------------
module deadline_task_scheduler_top import dts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [31:0] now,
	input  logic [31:0] interval,
	input  logic [19:0] call_tag,
	input  logic [31:0] ref_tag,
	input  logic [4:0]  slot,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  task_slot,
	output logic [1:0]  task_kind,
	output logic [19:0] out_call_tag,
	output logic [31:0] out_ref_tag
);

	state_t            state_q;
	func_t             func_q;
	logic [31:0]       now_q, intv_q, ref_tag_q, freq_q;
	logic [19:0]       call_tag_q;
	logic [SLOT_W-1:0] slot_q;

	kind_t             kind_q [SLOTS];
	logic [19:0]       call_q [SLOTS];
	logic [31:0]       ref_q  [SLOTS];
	logic [SLOTS-1:0]  used_q;
	logic [IDX_W-1:0]  fwd_q  [SLOTS];
	logic [IDX_W-1:0]  bck_q  [SLOTS];
	logic [IDX_W-1:0]  head_q, tail_q, free_top_q, running_q;
	logic [IDX_W-1:0]  cur_q, at_q;

	logic [31:0]       due_q [SLOTS];
	logic [31:0]       per_q [SLOTS];

	logic              done_q;
	status_t           status_q;
	logic [4:0]        task_slot_q;
	kind_t             task_kind_q;
	logic [19:0]       out_call_q;
	logic [31:0]       out_ref_q;

	logic [31:0]       ticks;

	dts_mul u_mul (
		.clk   (clk),
		.a     (intv_q),
		.b     (freq_q),
		.ticks (ticks)
	);

	function automatic logic due_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic [IDX_W-1:0] rd_bck(input logic [IDX_W-1:0] x);
		return (x == ROOT) ? tail_q : bck_q[x[SLOT_W-1:0]];
	endfunction

	// due time / period write port
	logic              due_we, per_we;
	logic [SLOT_W-1:0] due_wa, per_wa;
	logic [31:0]       due_wd;

	// decode helpers
	logic [SLOT_W-1:0] run_i, top_i, cur_i, at_i, head_i;
	logic [IDX_W-1:0]  run_f, run_b, sl_f, sl_b, ins_b, it_nxt;
	logic              hit, ins_here;

	assign run_i  = running_q[SLOT_W-1:0];
	assign top_i  = free_top_q[SLOT_W-1:0];
	assign cur_i  = cur_q[SLOT_W-1:0];
	assign at_i   = at_q[SLOT_W-1:0];
	assign head_i = head_q[SLOT_W-1:0];
	assign run_f  = fwd_q[run_i];
	assign run_b  = bck_q[run_i];
	assign sl_f   = fwd_q[slot_q];
	assign sl_b   = bck_q[slot_q];
	assign ins_b  = rd_bck(at_q);
	assign it_nxt = fwd_q[at_i];
	assign ins_here = (at_q == ROOT) || due_before(due_q[cur_i], due_q[at_i]);

	always_comb begin
		if (call_tag_q == 20'd0) begin
			hit = (ref_q[at_i] == ref_tag_q);
		end else if (ref_tag_q == 32'd0) begin
			hit = (call_q[at_i] == call_tag_q);
		end else begin
			hit = (call_q[at_i] == call_tag_q) && (ref_q[at_i] == ref_tag_q);
		end
	end

	always_comb begin
		due_we = 1'b0;
		per_we = 1'b0;
		due_wa = slot_q;
		per_wa = slot_q;
		due_wd = now_q;
		case (state_q)
			S_DECODE: begin
				if (func_q == F_WAKE && used_q[slot_q]) begin
					due_we = 1'b1;
				end else if (func_q == F_COMPLETE && running_q != ROOT
						&& kind_q[run_i] != K_CANCELED) begin
					due_we = 1'b1;
					due_wa = run_i;
					due_wd = per_q[run_i]
						+ ((kind_q[run_i] == K_PERIODIC) ? due_q[run_i] : now_q);
				end
			end
			S_APPLY: begin
				if (func_q == F_ADJUST) begin
					per_we = 1'b1;
				end else begin
					per_we = 1'b1;
					per_wa = top_i;
					due_we = 1'b1;
					due_wa = top_i;
					due_wd = now_q + ticks;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (due_we) begin
			due_q[due_wa] <= due_wd;
		end
		if (per_we) begin
			per_q[per_wa] <= ticks;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			func_q     <= func_t'(func);
			now_q      <= now;
			intv_q     <= interval;
			call_tag_q <= call_tag;
			ref_tag_q  <= ref_tag;
			slot_q     <= slot[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			freq_q      <= 32'd120000000;
			used_q      <= '0;
			head_q      <= ROOT;
			tail_q      <= ROOT;
			free_top_q  <= '0;
			running_q   <= ROOT;
			cur_q       <= ROOT;
			at_q        <= ROOT;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			task_slot_q <= '0;
			task_kind_q <= K_CANCELED;
			out_call_q  <= '0;
			out_ref_q   <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				kind_q[i] <= K_CANCELED;
				call_q[i] <= '0;
				ref_q[i]  <= '0;
				fwd_q[i]  <= IDX_W'(i + 1);
				bck_q[i]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				freq_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q    <= ST_OK;
						task_slot_q <= '0;
						task_kind_q <= K_CANCELED;
						out_call_q  <= '0;
						out_ref_q   <= '0;
						state_q     <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (func_q)
						F_ADD_SLEEP, F_ADD_PER: begin
							if (free_top_q == ROOT) begin
								status_q <= ST_NO_SLOT;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_APPLY;
							end
						end
						F_ADJUST: begin
							if (used_q[slot_q]) begin
								state_q <= S_APPLY;
							end else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						F_WAKE: begin
							if (used_q[slot_q]) begin
								// unlink, then reinsert at now
								if (sl_b == ROOT) head_q <= sl_f;
								else fwd_q[sl_b[SLOT_W-1:0]] <= sl_f;
								if (sl_f == ROOT) tail_q <= sl_b;
								else bck_q[sl_f[SLOT_W-1:0]] <= sl_b;
								cur_q   <= IDX_W'(slot_q);
								state_q <= S_SEEK;
							end else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						F_CANCEL: begin
							at_q    <= head_q;
							state_q <= S_CAN;
						end
						F_DISPATCH: begin
							if (head_q == ROOT || due_before(now_q, due_q[head_i])) begin
								status_q <= ST_NOT_DUE;
							end else begin
								running_q   <= head_q;
								task_slot_q <= 5'(head_i);
								task_kind_q <= kind_q[head_i];
								out_call_q  <= call_q[head_i];
								out_ref_q   <= ref_q[head_i];
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						F_COMPLETE: begin
							if (running_q == ROOT) begin
								status_q <= ST_NOT_RUN;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								running_q   <= ROOT;
								task_slot_q <= 5'(run_i);
								if (run_b == ROOT) head_q <= run_f;
								else fwd_q[run_b[SLOT_W-1:0]] <= run_f;
								if (run_f == ROOT) tail_q <= run_b;
								else bck_q[run_f[SLOT_W-1:0]] <= run_b;
								if (kind_q[run_i] == K_CANCELED) begin
									// push back on the free stack
									fwd_q[run_i]  <= free_top_q;
									free_top_q    <= running_q;
									used_q[run_i] <= 1'b0;
									done_q        <= 1'b1;
									state_q       <= S_IDLE;
								end else begin
									cur_q   <= running_q;
									state_q <= S_SEEK;
								end
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_APPLY: begin
					if (func_q == F_ADJUST) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						// pop the free stack
						free_top_q    <= fwd_q[top_i];
						used_q[top_i] <= 1'b1;
						kind_q[top_i] <= (func_q == F_ADD_SLEEP) ? K_SLEEP : K_PERIODIC;
						call_q[top_i] <= call_tag_q;
						ref_q[top_i]  <= ref_tag_q;
						task_slot_q   <= 5'(top_i);
						task_kind_q   <= (func_q == F_ADD_SLEEP) ? K_SLEEP : K_PERIODIC;
						out_call_q    <= call_tag_q;
						out_ref_q     <= ref_tag_q;
						cur_q         <= free_top_q;
						state_q       <= S_SEEK;
					end
				end
				S_SEEK: begin
					at_q    <= head_q;
					state_q <= S_INS;
				end
				S_INS: begin
					if (ins_here) begin
						// link cur between ins_b and at
						fwd_q[cur_i] <= at_q;
						bck_q[cur_i] <= ins_b;
						if (at_q == ROOT) tail_q <= cur_q;
						else bck_q[at_i] <= cur_q;
						if (ins_b == ROOT) head_q <= cur_q;
						else fwd_q[ins_b[SLOT_W-1:0]] <= cur_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						at_q <= it_nxt;
					end
				end
				S_CAN: begin
					if (at_q == ROOT) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						at_q <= it_nxt;
						if (hit) begin
							kind_q[at_i] <= K_CANCELED;
							call_q[at_i] <= '0;
							ref_q[at_i]  <= '0;
							if (at_q != running_q) begin
								if (ins_b == ROOT) head_q <= it_nxt;
								else fwd_q[ins_b[SLOT_W-1:0]] <= it_nxt;
								if (it_nxt == ROOT) tail_q <= ins_b;
								else bck_q[it_nxt[SLOT_W-1:0]] <= ins_b;
								fwd_q[at_i]  <= free_top_q;
								free_top_q   <= at_q;
								used_q[at_i] <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign task_slot    = task_slot_q;
	assign task_kind    = task_kind_q;
	assign out_call_tag = out_call_q;
	assign out_ref_tag  = out_ref_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe outside idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> (busy && !done_q))
		else $error("accepted transaction did not raise busy");

	a_running_used: assert property (@(posedge clk) disable iff (!arst_n)
		(running_q == ROOT) || used_q[run_i])
		else $error("running task is not allocated");

	a_free_top_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((free_top_q == ROOT) || !used_q[top_i]))
		else $error("free stack top is allocated");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline task scheduler testbench
// Drives add, adjust, wake, cancel, dispatch, complete and no-op transactions with
// random gaps, predicts every result with a behavioral copy of the slot pool
// and sorted queue, and compares each done strobe field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import dts_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 1030;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  task_slot;
		logic [1:0]  task_kind;
		logic [19:0] call_tag;
		logic [31:0] ref_tag;
	} sched_result_t;

	typedef struct {
		func_t       fn;
		logic [31:0] now;
		logic [31:0] interval;
		logic [19:0] call_tag;
		logic [31:0] ref_tag;
		logic [4:0]  slot;
		bit          has_fixed;
		status_t     fixed_status;
	} sched_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  func = '0;
	logic [31:0] now = '0;
	logic [31:0] interval = '0;
	logic [19:0] call_tag = '0;
	logic [31:0] ref_tag = '0;
	logic [4:0]  slot = '0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        done;
	logic [1:0]  status;
	logic [4:0]  task_slot;
	logic [1:0]  task_kind;
	logic [19:0] out_call_tag;
	logic [31:0] out_ref_tag;

	// scheduler copy
	logic [31:0] m_freq;
	kind_t       m_kind [SLOTS];
	logic [19:0] m_call [SLOTS];
	logic [31:0] m_ref [SLOTS];
	logic [31:0] m_due [SLOTS];
	logic [31:0] m_period [SLOTS];
	bit          m_busy [SLOTS];
	int          m_fwd [SLOTS+1];
	int          m_back [SLOTS+1];
	int          m_free_top;
	int          m_running;

	sched_result_t pending_results[$];
	int            error_count = 0;
	int            idle_cycles = 0;
	int            send_idle_pct = 34;
	logic [31:0]   clock_now = 32'h1000;
	logic [19:0]   call_pool [4] = '{20'h00001, 20'hFFFFF, 20'h00042, 20'h0A5A5};
	logic [31:0]   ref_pool [4] = '{32'h00000001, 32'hFFFFFFFF, 32'h0000BEEF, 32'h12345678};

	always #5 clk = ~clk;

	deadline_task_scheduler_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.now(now), .interval(interval), .call_tag(call_tag), .ref_tag(ref_tag),
		.slot(slot), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.status(status), .task_slot(task_slot), .task_kind(task_kind),
		.out_call_tag(out_call_tag), .out_ref_tag(out_ref_tag)
	);

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	function automatic logic [31:0] ticks_of(input logic [31:0] fixed);
		logic [63:0] p;
		p = {32'd0, fixed} * {32'd0, m_freq};
		return p[55:24];
	endfunction

	function automatic bit earlier(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	task automatic sched_reset();
		for (int i = 0; i < SLOTS; i++) begin
			m_kind[i] = K_CANCELED; m_call[i] = '0; m_ref[i] = '0;
			m_due[i] = '0; m_period[i] = '0; m_busy[i] = 0;
			m_fwd[i] = i + 1; m_back[i] = 0;
		end
		m_fwd[SLOTS] = SLOTS;
		m_back[SLOTS] = SLOTS;
		m_free_top = 0;
		m_running = SLOTS;
		m_freq = 32'd120000000;
	endtask

	task automatic unlink(input int s);
		m_fwd[m_back[s]] = m_fwd[s];
		m_back[m_fwd[s]] = m_back[s];
	endtask

	task automatic release_slot(input int s);
		unlink(s);
		m_fwd[s] = m_free_top;
		m_free_top = s;
		m_busy[s] = 0;
	endtask

	task automatic insert_by_due(input int s);
		int at;
		int guard;
		at = m_fwd[SLOTS];
		guard = 0;
		while (at != SLOTS && guard <= SLOTS) begin
			if (earlier(m_due[s], m_due[at]))
				break;
			at = m_fwd[at];
			guard++;
		end
		m_fwd[s] = at;
		m_back[s] = m_back[at];
		m_back[at] = s;
		m_fwd[m_back[s]] = s;
	endtask

	function automatic int queue_head();
		return m_fwd[SLOTS];
	endfunction

	task automatic schedule_step(input sched_cmd_t c, output sched_result_t r);
		int s;
		int it;
		int t;
		int guard;
		bit hit;
		r = '0;
		case (c.fn)
			F_ADD_SLEEP, F_ADD_PER: begin
				if (m_free_top == SLOTS) begin
					r.status = ST_NO_SLOT;
				end else begin
					s = m_free_top;
					m_free_top = m_fwd[s];
					m_busy[s] = 1;
					m_kind[s] = (c.fn == F_ADD_SLEEP) ? K_SLEEP : K_PERIODIC;
					m_call[s] = c.call_tag;
					m_ref[s] = c.ref_tag;
					m_period[s] = ticks_of(c.interval);
					m_due[s] = c.now + m_period[s];
					insert_by_due(s);
					r.task_slot = 5'(s); r.task_kind = m_kind[s];
					r.call_tag = c.call_tag; r.ref_tag = c.ref_tag;
				end
			end
			F_ADJUST, F_WAKE: begin
				if (m_busy[c.slot]) begin
					if (c.fn == F_ADJUST) begin
						m_period[c.slot] = ticks_of(c.interval);
					end else begin
						unlink(c.slot);
						m_due[c.slot] = c.now;
						insert_by_due(c.slot);
					end
				end
			end
			F_CANCEL: begin
				it = m_fwd[SLOTS];
				guard = 0;
				while (it != SLOTS && guard <= SLOTS) begin
					t = it;
					it = m_fwd[it];
					guard++;
					if (c.call_tag == 0)
						hit = m_ref[t] == c.ref_tag;
					else if (c.ref_tag == 0)
						hit = m_call[t] == c.call_tag;
					else
						hit = m_call[t] == c.call_tag && m_ref[t] == c.ref_tag;
					if (hit) begin
						m_kind[t] = K_CANCELED; m_call[t] = '0; m_ref[t] = '0;
						if (t != m_running)
							release_slot(t);
					end
				end
			end
			F_DISPATCH: begin
				s = m_fwd[SLOTS];
				if (s == SLOTS || earlier(c.now, m_due[s])) begin
					r.status = ST_NOT_DUE;
				end else begin
					m_running = s;
					r.task_slot = 5'(s); r.task_kind = m_kind[s];
					r.call_tag = m_call[s]; r.ref_tag = m_ref[s];
				end
			end
			F_COMPLETE: begin
				if (m_running == SLOTS) begin
					r.status = ST_NOT_RUN;
				end else begin
					s = m_running;
					m_running = SLOTS;
					r.task_slot = 5'(s);
					if (m_kind[s] == K_CANCELED) begin
						release_slot(s);
					end else begin
						unlink(s);
						m_due[s] = m_period[s] +
							((m_kind[s] == K_PERIODIC) ? m_due[s] : c.now);
						insert_by_due(s);
					end
				end
			end
			default: ;
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t want;
		if (done) begin
			got = {status, task_slot, task_kind, out_call_tag, out_ref_tag};
			if (pending_results.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.task_slot !== want.task_slot)
					report_mismatch($sformatf("task_slot %0d, want %0d",
						got.task_slot, want.task_slot));
				if (got.task_kind !== want.task_kind)
					report_mismatch($sformatf("task_kind %0d, want %0d",
						got.task_kind, want.task_kind));
				if (got.call_tag !== want.call_tag)
					report_mismatch($sformatf("call_tag %h, want %h",
						got.call_tag, want.call_tag));
				if (got.ref_tag !== want.ref_tag)
					report_mismatch($sformatf("ref_tag %h, want %h", got.ref_tag, want.ref_tag));
			end
		end
	end

	// watchdog on cycles without any accepted transaction or result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("TEST FAILED");
			$finish;
		end
	end

	// start stays high after the accepting edge; the block is busy then
	task automatic send(input sched_cmd_t c);
		sched_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= c.fn; now <= c.now; interval <= c.interval;
		call_tag <= c.call_tag; ref_tag <= c.ref_tag; slot <= c.slot;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		schedule_step(c, r);
		if (c.has_fixed && r.status != c.fixed_status)
			report_mismatch($sformatf("predicted status %0d, table says %0d",
				r.status, c.fixed_status));
		pending_results.push_back(r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_freq(input logic [31:0] v);
		drain();
		cfg_we <= 1'b1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_freq = v;
	endtask

	function automatic sched_cmd_t cmd(input func_t fn, input logic [31:0] t,
		input logic [31:0] iv, input logic [19:0] ct, input logic [31:0] rt,
		input logic [4:0] sl, input bit fx, input status_t fs);
		sched_cmd_t c;
		c.fn = fn; c.now = t; c.interval = iv; c.call_tag = ct; c.ref_tag = rt;
		c.slot = sl; c.has_fixed = fx; c.fixed_status = fs;
		return c;
	endfunction

	// mostly realistic scheduler traffic with a clock that drifts forward
	function automatic sched_cmd_t random_cmd();
		sched_cmd_t c;
		int pick;
		pick = $urandom_range(99);
		clock_now += $urandom_range(3) == 0 ? $urandom : $urandom_range(2000);
		c = cmd(F_NOP, clock_now, $urandom_range(3) == 0 ? $urandom : $urandom_range(20000),
			$urandom_range(1) ? call_pool[$urandom_range(3)] : 20'($urandom),
			$urandom_range(1) ? ref_pool[$urandom_range(3)] : $urandom,
			5'($urandom_range(31)), 0, ST_OK);
		if ($urandom_range(9) == 0) c.call_tag = '0;
		if ($urandom_range(9) == 0) c.ref_tag = '0;
		if (pick < 14) c.fn = F_ADD_SLEEP;
		else if (pick < 28) c.fn = F_ADD_PER;
		else if (pick < 36) c.fn = F_ADJUST;
		else if (pick < 44) c.fn = F_WAKE;
		else if (pick < 52) c.fn = F_CANCEL;
		else if (pick < 76) c.fn = F_DISPATCH;
		else if (pick < 97) c.fn = F_COMPLETE;
		else c.fn = F_NOP;
		// keep most dispatches due
		if (c.fn == F_DISPATCH && queue_head() != SLOTS && $urandom_range(3) != 0)
			c.now = m_due[queue_head()] + $urandom_range(100);
		return c;
	endfunction

	sched_cmd_t directed_table [$];

	initial begin
		sched_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_table = '{
			cmd(F_COMPLETE, 0, 0, 0, 0, 0, 1, ST_NOT_RUN),
			cmd(F_DISPATCH, 0, 0, 0, 0, 0, 1, ST_NOT_DUE),
			cmd(F_ADD_SLEEP, 32'h0, 32'h0100_0000, 20'hFFFFF, 32'hFFFFFFFF, 0, 0, ST_OK),
			cmd(F_ADD_PER, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'h00001, 32'h1, 0, 0, ST_OK),
			cmd(F_ADD_PER, 32'h7FFFFFFF, 32'h0, 20'h0, 32'h0, 0, 0, ST_OK),
			cmd(F_ADJUST, 0, 32'hFFFFFFFF, 0, 0, 5'd1, 0, ST_OK),
			cmd(F_ADJUST, 0, 32'h1, 0, 0, 5'd31, 0, ST_OK),
			cmd(F_WAKE, 32'h80000000, 0, 0, 0, 5'd0, 0, ST_OK),
			cmd(F_WAKE, 0, 0, 0, 0, 5'd30, 0, ST_OK),
			cmd(F_DISPATCH, 32'h80000000, 0, 0, 0, 0, 0, ST_OK),
			cmd(F_COMPLETE, 32'h80000010, 0, 0, 0, 0, 0, ST_OK),
			cmd(F_DISPATCH, 32'hFFFFFFFF, 0, 0, 0, 0, 0, ST_OK),
			cmd(F_DISPATCH, 32'hFFFFFFFF, 0, 0, 0, 0, 0, ST_OK),
			cmd(F_CANCEL, 0, 0, 20'h0, 32'h0, 0, 0, ST_OK),
			cmd(F_CANCEL, 0, 0, 20'hFFFFF, 32'h0, 0, 0, ST_OK),
			cmd(F_CANCEL, 0, 0, 20'h00001, 32'h1, 0, 0, ST_OK),
			cmd(F_COMPLETE, 32'h0, 0, 0, 0, 0, 0, ST_OK),
			cmd(F_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 5'd31, 1, ST_OK)
		};
		// fill the pool and overflow it
		for (int i = 0; i < 33; i++)
			directed_table.push_back(cmd(F_ADD_SLEEP, 32'($urandom), 32'($urandom),
				20'(i + 1), 32'(i), 5'd0, 0, ST_OK));
		directed_table.push_back(cmd(F_ADD_PER, 0, 0, 1, 1, 0, 1, ST_NO_SLOT));
		directed_table.push_back(cmd(F_CANCEL, 0, 0, 20'h0, 32'h0, 0, 0, ST_OK));
		foreach (directed_table[i])
			send(directed_table[i]);

		write_freq(32'd1);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 65;
				write_freq(32'hFFFFFFFF);
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				write_freq(32'd120000000);
			end else if (i % 200 == 100) begin
				drain();
			end
			send(random_cmd());
		end

		drain();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- deadline_task_scheduler_top.f -----
sv/dts_pkg.sv
sv/dts_mul.sv
sv/deadline_task_scheduler_top.sv
test/tb_top.sv
